[rtl/core/rdfc_pkg.sv]
package rdfc_pkg;

  // Ring and buffer geometry.
  localparam int RING_DEPTH   = 64;
  localparam int BUFFER_BYTES = 4096;

  // Field widths.
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 7;
  localparam int LEN_W    = 16;
  localparam int ERR_W    = 8;
  localparam int TOTAL_W  = 22;
  localparam int DROP_W   = 32;
  localparam int OUTCOME_W = 2;

  // Stream widths, padded to whole bytes.
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 72;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef enum logic [OUTCOME_W-1:0] {
    OUTCOME_NOT_READY = 2'd0,
    OUTCOME_ACCEPT    = 2'd1,
    OUTCOME_DROP      = 2'd2
  } outcome_t;

  // One receive descriptor as it sits in the input register.
  typedef struct packed {
    logic [LEN_W-1:0] capacity;
    logic [LEN_W-1:0] desc_length;
    logic [ERR_W-1:0] desc_errors;
    logic             desc_end;
    logic             desc_done;
  } desc_t;

  // One result transaction.
  typedef struct packed {
    outcome_t           outcome;
    logic [LEN_W-1:0]   frame_length;
    logic [POS_W-1:0]   first_slot;
    logic [COUNT_W-1:0] slot_count;
    logic [POS_W-1:0]   tail_index;
    logic [DROP_W-1:0]  drop_total;
  } result_t;

  // Receive tail: one slot behind the read position, around the ring.
  function automatic logic [POS_W-1:0] tail_of(input logic [POS_W-1:0] pos);
    logic [POS_W-1:0] tail;
    if (pos == '0) begin
      tail = POS_W'(RING_DEPTH - 1);
    end else begin
      tail = pos - POS_W'(1);
    end
    return tail;
  endfunction

endpackage

[rtl/core/rdfc_in_reg.sv]
module rdfc_in_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // done [0], errors [8:1], length [24:9], capacity [40:25], zero pad above
  input  logic [rdfc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          item_valid,
  output rdfc_pkg::desc_t               item,
  input  logic                          item_take
);
  import rdfc_pkg::*;

  logic accept;

  // The register frees up in the same cycle the scan stage takes its item.
  assign s_axis_tready = !item_valid || item_take;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (item_take) begin
      item_valid <= 1'b0;
    end
  end

  // Unpack the descriptor fields on acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      item.desc_done   <= s_axis_tdata[0];
      item.desc_errors <= s_axis_tdata[8:1];
      item.desc_length <= s_axis_tdata[24:9];
      item.capacity    <= s_axis_tdata[40:25];
      item.desc_end    <= s_axis_tlast;
    end
  end

endmodule

[rtl/core/rdfc_scan.sv]
module rdfc_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  rdfc_pkg::desc_t   item,
  input  logic              out_free,
  output logic              item_take,
  output logic              res_valid,
  output rdfc_pkg::result_t res
);
  import rdfc_pkg::*;

  logic [POS_W-1:0]   read_position;
  logic [TOTAL_W-1:0] running_total;
  logic [COUNT_W-1:0] slot_tally;
  logic               bad_flag;
  logic [DROP_W-1:0]  drop_count;

  logic [POS_W-1:0]   read_position_next;
  logic [TOTAL_W-1:0] running_total_next;
  logic [COUNT_W-1:0] slot_tally_next;
  logic               bad_flag_next;
  logic [DROP_W-1:0]  drop_count_next;

  logic [TOTAL_W:0]   sum_wide;
  logic [TOTAL_W-1:0] sum_sat;
  logic [COUNT_W-1:0] tally_inc;
  logic [COUNT_W-1:0] pos_sum;
  logic [COUNT_W-1:0] pos_wrap;
  logic               desc_bad;
  logic               frame_end;
  logic               frame_bad;
  logic               drop;
  logic               produces;

  // Accumulate the descriptor and decide whether it closes the frame.
  always_comb begin
    sum_wide  = {1'b0, running_total} + (TOTAL_W + 1)'(item.desc_length);
    sum_sat   = (sum_wide > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
    desc_bad  = (item.desc_errors != '0) || (item.desc_length == '0) ||
                (item.desc_length > LEN_W'(BUFFER_BYTES)) ||
                (sum_sat > TOTAL_W'(item.capacity));
    tally_inc = slot_tally + COUNT_W'(1);
    frame_end = item.desc_end || (tally_inc >= COUNT_W'(RING_DEPTH));
    frame_bad = bad_flag || desc_bad || !item.desc_end;
    drop      = frame_bad || (sum_sat == '0) || (sum_sat > TOTAL_W'(16'hFFFF));
    pos_sum   = COUNT_W'(read_position) + tally_inc;
    pos_wrap  = (pos_sum >= COUNT_W'(RING_DEPTH)) ? pos_sum - COUNT_W'(RING_DEPTH) : pos_sum;
    produces  = !item.desc_done || frame_end;
  end

  // A descriptor that produces no result never waits on the output side.
  assign item_take = item_valid && (out_free || !produces);
  assign res_valid = item_take && produces;

  // Next state and result fields.
  always_comb begin
    read_position_next = read_position;
    running_total_next = running_total;
    slot_tally_next    = slot_tally;
    bad_flag_next      = bad_flag;
    drop_count_next    = drop_count;

    res.outcome      = OUTCOME_NOT_READY;
    res.frame_length = '0;
    res.first_slot   = read_position;
    res.slot_count   = '0;
    res.tail_index   = tail_of(read_position);
    res.drop_total   = drop_count;

    if (!item.desc_done) begin
      // Not ready: discard the partial scan and keep the position.
      running_total_next = '0;
      slot_tally_next    = '0;
      bad_flag_next      = 1'b0;
    end else if (frame_end) begin
      // Frame complete: accept or drop it and move past its descriptors.
      read_position_next = pos_wrap[POS_W-1:0];
      running_total_next = '0;
      slot_tally_next    = '0;
      bad_flag_next      = 1'b0;
      res.slot_count     = tally_inc;
      res.tail_index     = tail_of(pos_wrap[POS_W-1:0]);
      if (drop) begin
        drop_count_next  = drop_count + DROP_W'(1);
        res.outcome      = OUTCOME_DROP;
        res.drop_total   = drop_count + DROP_W'(1);
      end else begin
        res.outcome      = OUTCOME_ACCEPT;
        res.frame_length = sum_sat[LEN_W-1:0];
      end
    end else begin
      // Mid-frame descriptor: keep accumulating.
      running_total_next = sum_sat;
      slot_tally_next    = tally_inc;
      bad_flag_next      = bad_flag || desc_bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_position <= '0;
      running_total <= '0;
      slot_tally    <= '0;
      bad_flag      <= 1'b0;
      drop_count    <= '0;
    end else if (item_take) begin
      read_position <= read_position_next;
      running_total <= running_total_next;
      slot_tally    <= slot_tally_next;
      bad_flag      <= bad_flag_next;
      drop_count    <= drop_count_next;
    end
  end

endmodule

[rtl/core/rdfc_out_reg.sv]
module rdfc_out_reg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           res_valid,
  input  rdfc_pkg::result_t              res,
  output logic                           out_free,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_length [15:0], first_slot [21:16], slot_count [28:22],
  // tail_index [34:29], drop_total [66:35], zero pad above
  output logic [rdfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // outcome [1:0]
  output logic [rdfc_pkg::OUTCOME_W-1:0]  m_axis_tuser
);
  import rdfc_pkg::*;

  result_t held;

  // The register can load whenever it is empty or being emptied.
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      held <= res;
    end
  end

  // Pack the held result onto the stream.
  assign m_axis_tuser = held.outcome;
  assign m_axis_tdata = {5'b0, held.drop_total, held.tail_index, held.slot_count,
                         held.first_slot, held.frame_length};

endmodule

[rtl/core/rx_descriptor_frame_checker.sv]
// Receive descriptor frame checker.
// The input stream carries one receive descriptor per transaction in ring
// order from the current read position; tlast carries the end-of-packet bit.
// The output stream carries one result transaction when a frame closes (at
// end-of-packet or after a full ring of descriptors) or when a descriptor is
// not yet done. tuser gives the outcome: not ready, accepted or dropped.
// An input transaction is held in the input register, and the scan logic then
// loads any result that it produces into the output register.
// Throughput is one descriptor per cycle while no result waits for the output
// register; the running total, slot tally and bad flag are updated in one pass.
// Descriptors that produce no result keep flowing while the output stalls; a
// descriptor that produces a result waits in the input register until the
// output register is free, and the input then back-pressures through tready.
// Reset clears the read position, the scan state and the drop counter, and
// empties both registers.
module rx_descriptor_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // done [0], errors [8:1], length [24:9], capacity [40:25], zero pad above
  input  logic [rdfc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // frame_length [15:0], first_slot [21:16], slot_count [28:22],
  // tail_index [34:29], drop_total [66:35], zero pad above
  output logic [rdfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // outcome [1:0]
  output logic [rdfc_pkg::OUTCOME_W-1:0]  m_axis_tuser
);
  import rdfc_pkg::*;

  logic    item_valid;
  desc_t   item;
  logic    item_take;
  logic    out_free;
  logic    res_valid;
  result_t res;

  rdfc_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take)
  );

  rdfc_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .item_take  (item_take),
    .res_valid  (res_valid),
    .res        (res)
  );

  rdfc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res_valid     (res_valid),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[rtl/core/rdfc_checker.sv]
module rdfc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rdfc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [rdfc_pkg::OUTCOME_W-1:0]  m_axis_tuser
);
  import rdfc_pkg::*;

  logic out_accept;

  assign out_accept = m_axis_tvalid && m_axis_tready;

  // A stalled result transaction holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The output is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A not-ready result carries no length and no consumed slots.
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    out_accept && (m_axis_tuser == OUTCOME_NOT_READY) |->
      (m_axis_tdata[15:0] == '0) && (m_axis_tdata[28:22] == '0))
    else $error("not-ready result with nonzero length or count");

  // A not-ready result leaves the tail one slot behind the first slot.
  a_not_ready_tail: assert property (@(posedge clk) disable iff (rst)
    out_accept && (m_axis_tuser == OUTCOME_NOT_READY) |->
      (m_axis_tdata[34:29] == tail_of(m_axis_tdata[21:16])))
    else $error("not-ready result moved the tail");

  // An accepted frame has a nonzero length and consumed at least one slot.
  a_accept_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_accept && (m_axis_tuser == OUTCOME_ACCEPT) |->
      (m_axis_tdata[15:0] != '0) && (m_axis_tdata[28:22] != '0))
    else $error("accepted frame with zero length or count");

endmodule

bind rx_descriptor_frame_checker rdfc_checker u_rdfc_checker (.*);

[tb/tb_rx_descriptor_frame_checker.sv]
`timescale 1ns / 100ps

module tb_rx_descriptor_frame_checker;
  import rdfc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 10;

  // Kinds of entries in the stimulus backlog.
  typedef enum logic [1:0] {
    ITEM_DESC,
    ITEM_DRAIN,
    ITEM_HOLD
  } item_kind_t;

  typedef struct {
    item_kind_t  kind;
    int unsigned phase;
    desc_t       desc;
  } stim_item_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUTCOME_W-1:0]  m_axis_tuser;

  // Descriptors waiting to be offered and results still owed by the block.
  stim_item_t  desc_backlog[$];
  result_t     owed_results[$];
  desc_t       offered_desc;
  int unsigned fill_phase = 0;
  int unsigned desc_total = 0;
  int unsigned run_phase = 0;
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;

  // Shadow of the ring scan state.
  logic [POS_W-1:0]   ring_pos = '0;
  logic [TOTAL_W-1:0] scan_bytes = '0;
  logic [COUNT_W-1:0] scan_slots = '0;
  logic               scan_bad = 1'b0;
  logic [DROP_W-1:0]  drop_tally = '0;

  rx_descriptor_frame_checker u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned sender_gap_pct(input int unsigned phase);
    return (phase == 0) ? 22 : (phase == 1) ? 75 : 0;
  endfunction

  function automatic int unsigned receiver_gap_pct(input int unsigned phase);
    return (phase == 0) ? 75 : (phase == 1) ? 22 : 0;
  endfunction

  task automatic log_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(input string name, input longint unsigned got,
                               input longint unsigned want);
    if (got != want) begin
      log_error($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  // Advance the shadow scan by one accepted descriptor and queue any result.
  task automatic track_descriptor(input desc_t d);
    logic [TOTAL_W:0] sum;
    result_t          res;
    res.first_slot = ring_pos;
    res.frame_length = '0;
    if (!d.desc_done) begin
      // A descriptor not yet written back abandons the partial scan.
      scan_bytes = '0;
      scan_slots = '0;
      scan_bad = 1'b0;
      res.outcome = OUTCOME_NOT_READY;
      res.slot_count = '0;
      res.tail_index = ring_pos - POS_W'(1);
      res.drop_total = drop_tally;
      owed_results.push_back(res);
    end else begin
      sum = {1'b0, scan_bytes} + (TOTAL_W + 1)'(d.desc_length);
      if (sum > (TOTAL_W + 1)'(TOTAL_MAX)) begin
        sum = (TOTAL_W + 1)'(TOTAL_MAX);
      end
      if (d.desc_errors != '0 || d.desc_length == '0 ||
          d.desc_length > LEN_W'(BUFFER_BYTES) || sum > (TOTAL_W + 1)'(d.capacity)) begin
        scan_bad = 1'b1;
      end
      scan_bytes = sum[TOTAL_W-1:0];
      scan_slots = scan_slots + COUNT_W'(1);
      if (d.desc_end || scan_slots >= COUNT_W'(RING_DEPTH)) begin
        // A full ring without end-of-packet is a broken frame.
        if (!d.desc_end) begin
          scan_bad = 1'b1;
        end
        if (scan_bad || scan_bytes == '0 || scan_bytes > TOTAL_W'(16'hFFFF)) begin
          res.outcome = OUTCOME_DROP;
          drop_tally = drop_tally + 1;
        end else begin
          res.outcome = OUTCOME_ACCEPT;
          res.frame_length = scan_bytes[LEN_W-1:0];
        end
        res.slot_count = scan_slots;
        ring_pos = ring_pos + POS_W'(scan_slots);
        res.tail_index = ring_pos - POS_W'(1);
        res.drop_total = drop_tally;
        owed_results.push_back(res);
        scan_bytes = '0;
        scan_slots = '0;
        scan_bad = 1'b0;
      end
    end
  endtask

  // Compare one result transaction with the oldest expectation.
  task automatic check_result(input logic [OUT_DATA_W-1:0] data,
                              input logic [OUTCOME_W-1:0] user);
    result_t want;
    if (owed_results.size() == 0) begin
      log_error($sformatf("result with no expectation, outcome %0d", user));
    end else begin
      want = owed_results.pop_front();
      compare_field("outcome", user, want.outcome);
      compare_field("frame_length", data[15:0], want.frame_length);
      compare_field("first_slot", data[21:16], want.first_slot);
      compare_field("slot_count", data[28:22], want.slot_count);
      compare_field("tail_index", data[34:29], want.tail_index);
      compare_field("drop_total", data[66:35], want.drop_total);
      if (data[OUT_DATA_W-1:67] != '0) begin
        log_error("nonzero padding in result data");
      end
    end
  endtask

  task automatic add_marker(input item_kind_t kind);
    stim_item_t it;
    it.kind = kind;
    it.phase = fill_phase;
    it.desc = '0;
    desc_backlog.push_back(it);
  endtask

  task automatic add_desc(input bit done, input bit last, input logic [7:0] errs,
                          input logic [15:0] len, input logic [15:0] cap);
    stim_item_t it;
    it.kind = ITEM_DESC;
    it.phase = fill_phase;
    it.desc.desc_done = done;
    it.desc.desc_end = last;
    it.desc.desc_errors = errs;
    it.desc.desc_length = len;
    it.desc.capacity = cap;
    desc_backlog.push_back(it);
    desc_total++;
  endtask

  function automatic logic [15:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      return 16'($urandom_range(1, BUFFER_BYTES));
    end else if (r < 94) begin
      return 16'($urandom_range(0, 65535));
    end else if (r < 97) begin
      return 16'(BUFFER_BYTES);
    end
    return 16'(BUFFER_BYTES + 1);
  endfunction

  function automatic logic [15:0] pick_capacity();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      return 16'hFFFF;
    end else if (r < 85) begin
      return 16'($urandom_range(1, 16384));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  // A run of done descriptors, optionally closed by end-of-packet, with
  // occasional error bytes when noisy.
  task automatic add_frame(input int unsigned n_slots, input bit closed, input bit noisy);
    logic [15:0] cap;
    logic [7:0]  errs;
    cap = pick_capacity();
    for (int unsigned i = 0; i < n_slots; i++) begin
      errs = (noisy && $urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      add_desc(1'b1, closed && (i == n_slots - 1), errs, pick_length(), cap);
    end
  endtask

  // Largest frame that still fits: fifteen full buffers and one short one.
  task automatic add_max_frame();
    for (int unsigned i = 0; i < 15; i++) begin
      add_desc(1'b1, 1'b0, 8'h00, 16'(BUFFER_BYTES), 16'hFFFF);
    end
    add_desc(1'b1, 1'b1, 8'h00, 16'(BUFFER_BYTES - 1), 16'hFFFF);
  endtask

  task automatic add_random_until(input int unsigned target);
    int unsigned r;
    int unsigned k;
    while (desc_total < target) begin
      r = $urandom_range(0, 199);
      if (r < 140) begin
        // Closed frames, mostly short, with occasional bad descriptors.
        k = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
        add_frame(k, 1'b1, 1'b1);
      end else if (r < 170) begin
        add_desc(1'b0, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else if (r < 188) begin
        // Frame cut short by a descriptor that is not done yet.
        add_frame($urandom_range(1, 5), 1'b0, 1'b1);
        add_desc(1'b0, 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end else if (r == 188) begin
        add_frame(RING_DEPTH, 1'b0, 1'b0);
      end else if (r == 189) begin
        add_max_frame();
      end else begin
        add_desc(1'($urandom), 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
      end
    end
  endtask

  task automatic build_stimulus();
    // Directed opening: not ready at reset, field extremes and per-descriptor bad cases.
    add_desc(1'b0, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_desc(1'b1, 1'b1, 8'h00, 16'd1, 16'd1);
    add_desc(1'b1, 1'b1, 8'h00, 16'(BUFFER_BYTES), 16'hFFFF);
    add_desc(1'b1, 1'b1, 8'h00, 16'(BUFFER_BYTES + 1), 16'hFFFF);
    add_desc(1'b1, 1'b1, 8'h00, 16'd0, 16'hFFFF);
    add_desc(1'b1, 1'b1, 8'h01, 16'd100, 16'hFFFF);
    add_desc(1'b1, 1'b1, 8'h80, 16'd100, 16'hFFFF);
    add_desc(1'b1, 1'b0, 8'h00, 16'd3000, 16'd5000);
    add_desc(1'b1, 1'b1, 8'h00, 16'd3000, 16'd5000);
    add_desc(1'b1, 1'b1, 8'h00, 16'd10, 16'd0);
    for (int unsigned i = 0; i < 3; i++) begin
      add_desc(1'b1, i == 2, 8'h00, 16'(BUFFER_BYTES), 16'hFFFF);
    end
    // A bad partial scan is discarded by a not-ready descriptor.
    add_desc(1'b1, 1'b0, 8'h00, 16'd500, 16'hFFFF);
    add_desc(1'b1, 1'b0, 8'h04, 16'd500, 16'hFFFF);
    add_desc(1'b0, 1'b0, 8'h00, 16'd0, 16'd0);
    add_desc(1'b1, 1'b1, 8'h00, 16'd42, 16'd42);
    add_desc(1'b1, 1'b1, 8'h00, 16'hFFFF, 16'hFFFF);

    add_random_until(500);
    add_marker(ITEM_DRAIN);
    fill_phase = 1;
    add_random_until(950);
    add_marker(ITEM_DRAIN);
    fill_phase = 2;
    // Stall the output while single-descriptor frames keep coming.
    add_marker(ITEM_HOLD);
    for (int unsigned i = 0; i < 12; i++) begin
      add_frame(1, 1'b1, 1'b0);
    end
    add_frame(RING_DEPTH, 1'b0, 1'b0);
    add_max_frame();
    add_random_until(1450);
  endtask

  // Descriptor driver: offers backlog entries and honors pause markers.
  always @(posedge clk) begin
    bit         drive;
    stim_item_t head;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_descriptor(offered_desc);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        drive = 1'b0;
        if (desc_backlog.size() != 0 && desc_backlog[0].kind == ITEM_HOLD) begin
          hold_req <= ~hold_req;
          void'(desc_backlog.pop_front());
        end
        if (desc_backlog.size() != 0 && desc_backlog[0].kind == ITEM_DRAIN &&
            owed_results.size() == 0) begin
          void'(desc_backlog.pop_front());
        end
        if (desc_backlog.size() != 0 && desc_backlog[0].kind == ITEM_DESC) begin
          head = desc_backlog[0];
          run_phase <= head.phase;
          if ($urandom_range(0, 99) >= sender_gap_pct(head.phase)) begin
            void'(desc_backlog.pop_front());
            offered_desc = head.desc;
            drive = 1'b1;
          end
        end
        s_axis_tvalid <= drive;
        if (drive) begin
          s_axis_tdata <= IN_DATA_W'({head.desc.capacity, head.desc.desc_length,
                                      head.desc.desc_errors, head.desc.desc_done});
          s_axis_tlast <= head.desc.desc_end;
        end
      end
    end
  end

  // Result monitor with random backpressure and the long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result(m_axis_tdata, m_axis_tuser);
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_gap_pct(run_phase));
      end
    end
  end

  // Watchdog on cycles without any transaction on either side.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (desc_backlog.size() != 0 || s_axis_tvalid) begin
      @(posedge clk);
    end
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      log_error($sformatf("%0d results never arrived", owed_results.size()));
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[rx_descriptor_frame_checker.f]
rtl/core/rdfc_pkg.sv
rtl/core/rdfc_in_reg.sv
rtl/core/rdfc_scan.sv
rtl/core/rdfc_out_reg.sv
rtl/core/rx_descriptor_frame_checker.sv
rtl/core/rdfc_checker.sv
tb/tb_rx_descriptor_frame_checker.sv
